>>> rtl/edf_ready_queue_scheduler_core_macros.svh
// Assertion macros used by the checker of the scheduler core.
// Depends on nothing; the including scope supplies clock and reset.
`ifndef EDF_READY_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define EDF_READY_QUEUE_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ERQS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ERQS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/erqs_pkg.sv
// Shared types and constants of the EDF ready queue scheduler core.
// Depends on nothing; used by the controller, datapath, top level and checker.
package erqs_pkg;

   localparam int REQ_W       = 2;
   localparam int ID_PORT_W   = 16;
   localparam int TIME_W      = 64;
   localparam int REL_W       = 32;
   localparam int ORDER_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ENQUEUE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_PICK     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUP       = 3'd4;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } stat_type;

endpackage

>>> rtl/erqs_ctrl.sv
// Controller of the scheduler core: sequences accept, table scan and commit,
// and owns the result beat's valid flag. Depends on erqs_pkg.
module erqs_ctrl
   import erqs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // The last slot read is compared during this cycle.
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/erqs_dp.sv
// Datapath of the scheduler core: task table memories, ready and registered
// flags, the one-slot-per-cycle scan, commit logic and result registers.
// Depends on erqs_pkg.
module erqs_dp
   import erqs_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [ID_PORT_W-1:0]   req_task_id,
   input  logic [TIME_W-1:0]      req_now,
   input  logic [REL_W-1:0]       req_rel_deadline,
   input  logic                   req_task_dead,
   input  logic [ID_PORT_W-1:0]   req_curr_task_id,
   input  logic                   req_curr_is_edf,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_pick_valid,
   output logic [ID_PORT_W-1:0]   rsp_pick_task_id,
   output logic                   rsp_resched,
   output logic [COUNT_OUT_W-1:0] rsp_ready_count
);

   localparam int IdW   = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
   localparam int SlotW = $clog2(MAX_TASKS);
   localparam int CntW  = $clog2(MAX_TASKS + 1);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_TASKS - 1);

   // Request registers, loaded when a beat is accepted.
   logic [REQ_W-1:0]  type_ff;
   logic [IdW-1:0]    id_ff;
   logic [TIME_W-1:0] now_ff;
   logic [REL_W-1:0]  rel_ff;
   logic              dead_ff;
   logic [IdW-1:0]    curr_ff;
   logic              curr_edf_ff;
   logic [TIME_W-1:0] abs_ff;
   logic [TIME_W:0]   abs_sum;

   // Table storage.
   logic [IdW-1:0]     id_mem [MAX_TASKS];
   logic [TIME_W-1:0]  dl_mem [MAX_TASKS];
   logic [ORDER_W-1:0] ord_mem[MAX_TASKS];
   logic [MAX_TASKS-1:0] registered_ff, registered_in;
   logic [MAX_TASKS-1:0] ready_ff, ready_in;
   logic [ORDER_W-1:0]   seq_ff, seq_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;

   // Scan pipeline.
   logic [SlotW-1:0]   scan_idx_ff;
   logic               cmp_vld_ff;
   logic [SlotW-1:0]   cmp_idx_ff;
   logic [IdW-1:0]     id_rd_ff;
   logic [TIME_W-1:0]  dl_rd_ff;
   logic [ORDER_W-1:0] ord_rd_ff;

   // Scan results.
   logic               found_ff, free_found_ff, curr_found_ff, best_found_ff;
   logic [SlotW-1:0]   hit_slot_ff, free_slot_ff;
   logic [TIME_W-1:0]  curr_dl_ff, best_dl_ff;
   logic [ORDER_W-1:0] best_age_ff;
   logic [IdW-1:0]     best_id_ff;

   logic               slot_reg, id_hit, curr_hit, free_hit, ready_hit, better;
   logic [ORDER_W-1:0] age_rd;

   // Commit outputs.
   logic               mem_we;
   logic [SlotW-1:0]   wr_slot;
   logic [TIME_W-1:0]  wr_dl;
   logic [ORDER_W-1:0] wr_ord;
   logic [STATUS_W-1:0] status_in;
   logic               pick_valid_in, resched_in;
   logic [ID_PORT_W-1:0] pick_id_in;
   logic [ID_PORT_W+IdW-1:0] pick_id_wide;
   logic [COUNT_OUT_W+CntW-1:0] cnt_wide;

   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_pick_valid_ff;
   logic [ID_PORT_W-1:0]   rsp_pick_task_id_ff;
   logic                   rsp_resched_ff;
   logic [COUNT_OUT_W-1:0] rsp_ready_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff     <= req_type;
         id_ff       <= req_task_id[IdW-1:0];
         now_ff      <= req_now;
         rel_ff      <= req_rel_deadline;
         dead_ff     <= req_task_dead;
         curr_ff     <= req_curr_task_id[IdW-1:0];
         curr_edf_ff <= req_curr_is_edf;
      end
   end

   // Saturating absolute deadline; settles long before commit.
   assign abs_sum = {1'b0, now_ff} + {{(TIME_W - REL_W + 1){1'b0}}, rel_ff};

   always_ff @(posedge clock) begin
      abs_ff <= abs_sum[TIME_W] ? {TIME_W{1'b1}} : abs_sum[TIME_W-1:0];
   end

   // Memories: one write port at commit, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[wr_slot]  <= id_ff;
         dl_mem[wr_slot]  <= wr_dl;
         ord_mem[wr_slot] <= wr_ord;
      end
      if (cmd.scan) begin
         id_rd_ff  <= id_mem[scan_idx_ff];
         dl_rd_ff  <= dl_mem[scan_idx_ff];
         ord_rd_ff <= ord_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
         if (cmd.load) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + SlotW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_idx_ff;
   end

   assign stat.scan_last = (scan_idx_ff == LastSlot);

   // Compare stage: one slot per cycle against the running results.
   assign slot_reg  = registered_ff[cmp_idx_ff];
   assign id_hit    = cmp_vld_ff && slot_reg && (id_rd_ff == id_ff);
   assign curr_hit  = cmp_vld_ff && slot_reg && (id_rd_ff == curr_ff);
   assign free_hit  = cmp_vld_ff && !slot_reg;
   assign ready_hit = cmp_vld_ff && ready_ff[cmp_idx_ff];
   assign age_rd    = seq_ff - ord_rd_ff;
   // On equal deadlines the larger age, that is the earlier enqueue, wins.
   assign better    = !best_found_ff || (dl_rd_ff < best_dl_ff) ||
                      ((dl_rd_ff == best_dl_ff) && (age_rd > best_age_ff));

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         curr_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         if (id_hit) begin
            found_ff <= 1'b1;
         end
         if (free_hit) begin
            free_found_ff <= 1'b1;
         end
         if (curr_hit) begin
            curr_found_ff <= 1'b1;
         end
         if (ready_hit) begin
            best_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (id_hit && !found_ff) begin
         hit_slot_ff <= cmp_idx_ff;
      end
      if (free_hit && !free_found_ff) begin
         free_slot_ff <= cmp_idx_ff;
      end
      if (curr_hit) begin
         curr_dl_ff <= dl_rd_ff;
      end
      if (ready_hit && better) begin
         best_dl_ff  <= dl_rd_ff;
         best_age_ff <= age_rd;
         best_id_ff  <= id_rd_ff;
      end
   end

   assign pick_id_wide = {{ID_PORT_W{1'b0}}, best_id_ff};

   // Commit: update the table and form the result beat.
   always_comb begin
      registered_in = registered_ff;
      ready_in      = ready_ff;
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      mem_we        = 1'b0;
      wr_slot       = hit_slot_ff;
      wr_dl         = abs_ff;
      wr_ord        = seq_ff;
      status_in     = ST_OK;
      pick_valid_in = 1'b0;
      pick_id_in    = '0;
      resched_in    = 1'b0;
      if (cmd.commit) begin
         unique case (type_ff)
            REQ_REGISTER: begin
               if (found_ff) begin
                  status_in = ST_DUP;
               end else if (!free_found_ff) begin
                  status_in = ST_FULL;
               end else begin
                  registered_in[free_slot_ff] = 1'b1;
                  mem_we  = 1'b1;
                  wr_slot = free_slot_ff;
                  wr_dl   = '0;
                  wr_ord  = '0;
               end
            end
            REQ_ENQUEUE: begin
               if (!found_ff) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  mem_we = 1'b1;
                  seq_in = seq_ff + ORDER_W'(1);
                  if (!ready_ff[hit_slot_ff]) begin
                     ready_in[hit_slot_ff] = 1'b1;
                     cnt_in = cnt_ff + CntW'(1);
                  end
               end
            end
            REQ_DEQUEUE: begin
               if (!found_ff) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  if (ready_ff[hit_slot_ff]) begin
                     ready_in[hit_slot_ff] = 1'b0;
                     cnt_in = cnt_ff - CntW'(1);
                  end
                  if (dead_ff) begin
                     registered_in[hit_slot_ff] = 1'b0;
                  end
               end
            end
            REQ_PICK: begin
               resched_in = !curr_edf_ff;
               if (!best_found_ff) begin
                  status_in = ST_EMPTY;
               end else begin
                  pick_valid_in = 1'b1;
                  pick_id_in    = pick_id_wide[ID_PORT_W-1:0];
                  if (curr_edf_ff) begin
                     if (!curr_found_ff) begin
                        status_in = ST_NOT_FOUND;
                     end else if (best_dl_ff < curr_dl_ff) begin
                        resched_in = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         ready_ff      <= '0;
         seq_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         registered_ff <= registered_in;
         ready_ff      <= ready_in;
         seq_ff        <= seq_in;
         cnt_ff        <= cnt_in;
      end
   end

   assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt_in};

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff       <= status_in;
         rsp_pick_valid_ff   <= pick_valid_in;
         rsp_pick_task_id_ff <= pick_id_in;
         rsp_resched_ff      <= resched_in;
         rsp_ready_count_ff  <= cnt_wide[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_pick_valid   = rsp_pick_valid_ff;
   assign rsp_pick_task_id = rsp_pick_task_id_ff;
   assign rsp_resched      = rsp_resched_ff;
   assign rsp_ready_count  = rsp_ready_count_ff;

endmodule

>>> rtl/edf_ready_queue_scheduler_core.sv
// Channel  | Handshake            | Beat contents
// ---------+----------------------+-----------------------------------------------
// req      | req_valid/req_ready  | request type, task id, time, deadline, flags
// rsp      | rsp_valid/rsp_ready  | status, pick, preempt flag, ready count
//
// An item passes through accept, a scan that reads one table slot per cycle
// through the single read port of the table memories, a compare of the last
// slot read and a commit, which waits while a stalled result is held.
// Reset is synchronous; the registered and ready flags clear at once, so there
// is no clearing pass. The result sits in an output register: the next beat is
// accepted while it waits, and only the commit of that next item stalls on it.
// Top level of the EDF ready queue scheduler; uses erqs_pkg, erqs_ctrl, erqs_dp.
module edf_ready_queue_scheduler_core
   import erqs_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [ID_PORT_W-1:0]   req_task_id,
   input  logic [TIME_W-1:0]      req_now,
   input  logic [REL_W-1:0]       req_rel_deadline,
   input  logic                   req_task_dead,
   input  logic [ID_PORT_W-1:0]   req_curr_task_id,
   input  logic                   req_curr_is_edf,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_pick_valid,
   output logic [ID_PORT_W-1:0]   rsp_pick_task_id,
   output logic                   rsp_resched,
   output logic [COUNT_OUT_W-1:0] rsp_ready_count
);

   cmd_type  cmd;
   stat_type stat;

   erqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   erqs_dp #(
      .MAX_TASKS (MAX_TASKS),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_task_id      (req_task_id),
      .req_now          (req_now),
      .req_rel_deadline (req_rel_deadline),
      .req_task_dead    (req_task_dead),
      .req_curr_task_id (req_curr_task_id),
      .req_curr_is_edf  (req_curr_is_edf),
      .rsp_status       (rsp_status),
      .rsp_pick_valid   (rsp_pick_valid),
      .rsp_pick_task_id (rsp_pick_task_id),
      .rsp_resched      (rsp_resched),
      .rsp_ready_count  (rsp_ready_count)
   );

endmodule

>>> rtl/erqs_checker.sv
// Port-level checker of the scheduler core and its bind to the top level.
// Depends on erqs_pkg and edf_ready_queue_scheduler_core_macros.svh.
`include "edf_ready_queue_scheduler_core_macros.svh"

module erqs_checker
   import erqs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    rsp_status,
   input logic                   rsp_pick_valid,
   input logic [ID_PORT_W-1:0]   rsp_pick_task_id,
   input logic [COUNT_OUT_W-1:0] rsp_ready_count
);

   // A stalled result beat keeps its contents.
   `ERQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_pick_task_id) && $stable(rsp_ready_count), "result beat changed while stalled")

   // A taken beat starts the table scan, so no beat is taken right after one.
   `ERQS_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "request taken during a scan")

   // Without a pick the task id field reads zero.
   `ERQS_ASSERT_IMPLY(a_no_pick_id, rsp_valid && !rsp_pick_valid, rsp_pick_task_id == '0, "task id without a pick")

   // An empty queue means no pick and a zero ready count.
   `ERQS_ASSERT_IMPLY(a_empty, rsp_valid && rsp_status == ST_EMPTY, !rsp_pick_valid && rsp_ready_count == '0, "empty status with ready tasks")

endmodule

bind edf_ready_queue_scheduler_core erqs_checker u_erqs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_pick_valid   (rsp_pick_valid),
   .rsp_pick_task_id (rsp_pick_task_id),
   .rsp_ready_count  (rsp_ready_count)
);
